// ----- rtl/core/i2cra_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cra_pkg: shared types for the I2C register access master
// Sequencer phases, architectural state, request and result records.
// ----------------------------------------------------------------------------
package i2cra_pkg;

  localparam int unsigned GapW = 20;

  // Which byte of the transfer is on the wire.
  localparam logic [1:0] BYTE_DEV   = 2'd0;
  localparam logic [1:0] BYTE_REG   = 2'd1;
  localparam logic [1:0] BYTE_THIRD = 2'd2;

  localparam logic [2:0] LAST_BIT = 3'd7;

  // Request kinds carried in tuser.
  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST0, PH_ST1, PH_ST2,
    PH_WB0, PH_WB1, PH_WB2,
    PH_AK0, PH_AK1, PH_AK2, PH_AK3,
    PH_RB0, PH_RB1,
    PH_NA0, PH_NA1, PH_NA2, PH_NA3,
    PH_SP0, PH_SP1, PH_SP2,
    PH_GAP
  } phase_e;

  typedef struct packed {
    phase_e          phase;
    logic [2:0]      bit_idx;
    logic [1:0]      byte_idx;
    logic [7:0]      shift;
    logic [7:0]      rd_buf;
    logic            cmd_read;
    logic [7:0]      cmd_dev;
    logic [7:0]      cmd_reg;
    logic [7:0]      cmd_data;
    logic [GapW-1:0] gap_cnt;
    logic            scl;
    logic            sda;
  } state_t;

  typedef struct packed {
    logic       kind;
    logic       is_read;
    logic [7:0] device_addr;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       awaiting_ack;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       sda_level;
    logic       scl_level;
  } res_t;

endpackage

// ----- rtl/core/i2cra_step.sv -----
// ----------------------------------------------------------------------------
// i2cra_step: one sequencer step
// Next state and result for one request, given the current state.
// ----------------------------------------------------------------------------
module i2cra_step (
  input  i2cra_pkg::state_t            state_i,
  input  i2cra_pkg::req_t              req_i,
  input  logic [i2cra_pkg::GapW-1:0]   gap_ticks_i,
  output i2cra_pkg::state_t            state_o,
  output i2cra_pkg::res_t              res_o
);
  import i2cra_pkg::*;

  state_t nxt;
  logic   done;

  function automatic logic [7:0] byte_sel(input state_t s, input logic [1:0] idx);
    logic [7:0] b;
    if (idx == BYTE_DEV)      b = s.cmd_dev;
    else if (idx == BYTE_REG) b = s.cmd_reg;
    else if (s.cmd_read)      b = s.cmd_dev | 8'h01;
    else                      b = s.cmd_data;
    return b;
  endfunction

  always_comb begin
    nxt  = state_i;
    done = 1'b0;
    if (req_i.kind == KIND_CMD) begin
      if (state_i.phase == PH_IDLE) begin
        nxt.cmd_read = req_i.is_read;
        nxt.cmd_dev  = req_i.device_addr;
        nxt.cmd_reg  = req_i.reg_addr;
        nxt.cmd_data = req_i.write_data;
        nxt.byte_idx = BYTE_DEV;
        nxt.bit_idx  = '0;
        nxt.gap_cnt  = '0;
        nxt.phase    = PH_ST0;
      end
    end else if (state_i.phase != PH_IDLE) begin
      case (state_i.phase)
        PH_ST0: begin nxt.scl = 1'b1; nxt.phase = PH_ST1; end
        PH_ST1: begin nxt.sda = 1'b1; nxt.phase = PH_ST2; end
        PH_ST2: begin
          nxt.sda     = 1'b0;
          nxt.shift   = byte_sel(state_i, state_i.byte_idx);
          nxt.bit_idx = '0;
          nxt.phase   = PH_WB0;
        end
        PH_WB0: begin nxt.scl = 1'b0; nxt.phase = PH_WB1; end
        PH_WB1: begin nxt.sda = state_i.shift[7]; nxt.phase = PH_WB2; end
        PH_WB2: begin
          nxt.scl   = 1'b1;
          nxt.shift = {state_i.shift[6:0], 1'b0};
          if (state_i.bit_idx == LAST_BIT) begin
            nxt.phase = PH_AK0;
          end else begin
            nxt.bit_idx = state_i.bit_idx + 3'd1;
            nxt.phase   = PH_WB0;
          end
        end
        PH_AK0: begin nxt.scl = 1'b0; nxt.phase = PH_AK1; end
        PH_AK1: begin nxt.sda = 1'b1; nxt.phase = PH_AK2; end
        PH_AK2: begin nxt.scl = 1'b1; nxt.phase = PH_AK3; end
        PH_AK3: begin
          // slave holds SDA high: keep waiting, no timeout
          if (!req_i.sda_in) begin
            nxt.scl = 1'b0;
            if (state_i.byte_idx == BYTE_DEV) begin
              nxt.byte_idx = BYTE_REG;
              nxt.shift    = byte_sel(state_i, BYTE_REG);
              nxt.bit_idx  = '0;
              nxt.phase    = PH_WB0;
            end else if (state_i.byte_idx == BYTE_REG) begin
              nxt.byte_idx = BYTE_THIRD;
              if (state_i.cmd_read) begin
                nxt.phase = PH_ST0;  // repeated start
              end else begin
                nxt.shift   = byte_sel(state_i, BYTE_THIRD);
                nxt.bit_idx = '0;
                nxt.phase   = PH_WB0;
              end
            end else if (state_i.byte_idx == BYTE_THIRD && state_i.cmd_read) begin
              nxt.rd_buf  = '0;
              nxt.bit_idx = '0;
              nxt.phase   = PH_RB0;
            end else begin
              nxt.phase = PH_SP0;
            end
          end
        end
        PH_RB0: begin nxt.scl = 1'b0; nxt.phase = PH_RB1; end
        PH_RB1: begin
          nxt.scl    = 1'b1;
          nxt.rd_buf = {state_i.rd_buf[6:0], req_i.sda_in};
          if (state_i.bit_idx == LAST_BIT) begin
            nxt.phase = PH_NA0;
          end else begin
            nxt.bit_idx = state_i.bit_idx + 3'd1;
            nxt.phase   = PH_RB0;
          end
        end
        PH_NA0: begin nxt.scl = 1'b0; nxt.phase = PH_NA1; end
        PH_NA1: begin nxt.sda = 1'b1; nxt.phase = PH_NA2; end
        PH_NA2: begin nxt.scl = 1'b1; nxt.phase = PH_NA3; end
        PH_NA3: begin nxt.scl = 1'b0; nxt.phase = PH_SP0; end
        PH_SP0: begin nxt.sda = 1'b0; nxt.phase = PH_SP1; end
        PH_SP1: begin nxt.scl = 1'b1; nxt.phase = PH_SP2; end
        PH_SP2: begin
          nxt.sda = 1'b1;
          if (!state_i.cmd_read && gap_ticks_i != '0) begin
            nxt.gap_cnt = gap_ticks_i;
            nxt.phase   = PH_GAP;
          end else begin
            nxt.phase = PH_IDLE;
            done      = 1'b1;
          end
        end
        PH_GAP: begin
          if (state_i.gap_cnt != '0) nxt.gap_cnt = state_i.gap_cnt - GapW'(1);
          if (nxt.gap_cnt == '0) begin
            nxt.phase = PH_IDLE;
            done      = 1'b1;
          end
        end
        default: nxt.phase = PH_IDLE;
      endcase
    end
  end

  assign state_o = nxt;

  assign res_o.scl_level    = nxt.scl;
  assign res_o.sda_level    = nxt.sda;
  assign res_o.busy_res     = (nxt.phase != PH_IDLE);
  assign res_o.done_res     = done;
  assign res_o.read_data    = nxt.rd_buf;
  assign res_o.awaiting_ack = (nxt.phase == PH_AK3);

endmodule

// ----- rtl/core/i2c_register_access_master.sv -----
// ----------------------------------------------------------------------------
// i2c_register_access_master: single register I2C read/write master
// Bit-banged sequencer, at most one SCL/SDA line event per tick request.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake            Content
// s_axis    in   tvalid/tready        tuser: kind; tdata: command operands, sda_in
// m_axis    out  tvalid/tready        tdata: line levels, busy, done, read byte, ack wait
// cfg       in   cfg_valid_i/ready_o  cfg_data_i: write_gap_ticks
//
// Flow: a request is registered on accept, stepped through the sequencer
// logic and lands in the result register; one request per cycle sustained
// while m_axis_tready stays high. The sequencer state update is the single
// step between the request register and the result register.
// Reset: async, active low; sequencer idle, both lines released, gap zero.
// Stalls: a full result register holds the step; the request register then
// fills and s_axis_tready drops. Config writes are taken in any cycle.
//
module i2c_register_access_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] is_read, [8:1] device_addr, [16:9] reg_addr, [24:17] write_data,
  // [25] sda_in, [31:26] zero
  input  logic [31:0] s_axis_tdata,
  // [0] kind: 0 command, 1 tick
  input  logic [0:0]  s_axis_tuser,
  // result
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res,
  // [11:4] read_data, [12] awaiting_ack, [15:13] zero
  output logic [15:0] m_axis_tdata,
  // configuration: write_gap_ticks
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [19:0] cfg_data_i
);
  import i2cra_pkg::*;

  // idle sequencer, both lines released
  localparam state_t StateRst = '{
    phase:    PH_IDLE,
    bit_idx:  3'd0,
    byte_idx: BYTE_DEV,
    shift:    8'h00,
    rd_buf:   8'h00,
    cmd_read: 1'b0,
    cmd_dev:  8'h00,
    cmd_reg:  8'h00,
    cmd_data: 8'h00,
    gap_cnt:  {GapW{1'b0}},
    scl:      1'b1,
    sda:      1'b1
  };

  logic            in_vld_q;
  req_t            in_req_q;
  logic            out_vld_q;
  res_t            out_res_q;
  state_t          state_q, state_d;
  res_t            step_res;
  logic [GapW-1:0] gap_ticks_q;
  logic            advance;

  // result register free or draining this cycle
  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_ticks_q <= '0;
    end else if (cfg_valid_i) begin
      gap_ticks_q <= cfg_data_i;
    end
  end

  // request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req_q.kind        <= s_axis_tuser[0];
      in_req_q.is_read     <= s_axis_tdata[0];
      in_req_q.device_addr <= s_axis_tdata[8:1];
      in_req_q.reg_addr    <= s_axis_tdata[16:9];
      in_req_q.write_data  <= s_axis_tdata[24:17];
      in_req_q.sda_in      <= s_axis_tdata[25];
    end
  end

  i2cra_step u_step (
    .state_i     (state_q),
    .req_i       (in_req_q),
    .gap_ticks_i (gap_ticks_q),
    .state_o     (state_d),
    .res_o       (step_res)
  );

  // sequencer state, updated once per stepped request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateRst;
    end else if (in_vld_q && advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q && advance) begin
      out_res_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_res_q.awaiting_ack, out_res_q.read_data,
                          out_res_q.done_res, out_res_q.busy_res,
                          out_res_q.sda_level, out_res_q.scl_level};

`ifndef SYNTHESIS
  // bus released whenever no transfer is running
  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_IDLE |-> state_q.scl && state_q.sda)
    else $error("lines not released while idle");

  // ack wait samples with SCL high and SDA released
  a_ack_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_AK3 |-> state_q.scl && state_q.sda)
    else $error("ack wait entered with wrong line levels");

  // a stalled request is not lost
  a_req_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q)
    else $error("request dropped under stall");

  // write gap only after a write
  a_gap_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_GAP |-> !state_q.cmd_read && state_q.gap_cnt != '0)
    else $error("gap phase inconsistent");
`endif

endmodule
